>>> rtl/core/mvsf_pkg.sv
// mvsf_pkg: shared codes and field widths of the memory value search filter.
// No dependencies.

package mvsf_pkg;

    localparam int SLOT_W  = 16;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 17;
    localparam int FMODE_W = 3;
    localparam int VWID_W  = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [FMODE_W-1:0]   t_fmode;
    typedef logic [VWID_W-1:0]    t_vwidth;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_VALUE_WIDTH   = 2'd0;
    localparam t_cfg_idx CFG_FILTER_MODE   = 2'd1;
    localparam t_cfg_idx CFG_COMPARE_VALUE = 2'd2;

    // value width codes
    localparam t_vwidth VW_BYTE = 2'd0;
    localparam t_vwidth VW_HALF = 2'd1;

    // filter modes
    localparam t_fmode FM_EQUAL     = 3'd0;
    localparam t_fmode FM_NOT_EQUAL = 3'd1;
    localparam t_fmode FM_GREATER   = 3'd2;
    localparam t_fmode FM_LESS      = 3'd3;
    localparam t_fmode FM_CHANGED   = 3'd4;
    localparam t_fmode FM_UNCHANGED = 3'd5;

    // item commands
    localparam logic CMD_RESET  = 1'b0;
    localparam logic CMD_FILTER = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

>>> rtl/core/memory_value_search_filter_unit.sv
// memory_value_search_filter_unit: narrows candidate memory slots over scan passes.
// Candidate bits and snapshots live in two synchronous memories.
// Depends on mvsf_pkg.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tdata slot_index, current_value; tuser cmd;
//           |     |                        | tlast pass_end
//  m_axis   | out | m_axis_tvalid/tready   | tdata slot_out, kept, kept_count; tuser ignored;
//           |     |                        | tlast done_res
//  cfg      | in  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data (always ready)
//
// One item per cycle sustained while m_axis_tready allows; each item passes the memory read
// into the compare stage, then compare and write-back into the output register.
// After reset a clearing pass zeroes the candidate memory, with
// s_axis_tready low; configuration writes are taken during it.
// A back-to-back hit on the same slot is served from the forwarding register.
// Output stalls back up through the compare stage to s_axis_tready.

module memory_value_search_filter_unit
    import mvsf_pkg::*;
#(
    parameter int SLOTS = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // [15:0] slot_index, [47:16] current_value
    input  logic                 s_axis_tuser,   // [0] cmd
    input  logic                 s_axis_tlast,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,   // [15:0] slot_out, [16] kept,
                                                 // [33:17] kept_count, [39:34] zero
    output logic                 m_axis_tuser,   // [0] ignored
    output logic                 m_axis_tlast,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  t_cfg_idx             i_cfg_index,
    input  logic [VALUE_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W  = 26;
    localparam int EXT_W  = ADDR_W + SLOT_W;

    // configuration
    t_vwidth              r_value_width;
    t_fmode               r_filter_mode;
    logic [VALUE_W-1:0]   r_compare_value;

    // memories
    logic                 r_cand_mem [SLOTS];
    logic [VALUE_W-1:0]   r_snap_mem [SLOTS];
    logic                 r_rd_cand;
    logic [VALUE_W-1:0]   r_rd_snap;

    // clearing pass
    logic                 r_clr_busy;
    logic [ADDR_W-1:0]    r_clr_addr;

    // compare stage
    logic                 r_s1_valid;
    logic                 r_s1_cmd;
    logic [SLOT_W-1:0]    r_s1_slot;
    logic [VALUE_W-1:0]   r_s1_cur;
    logic                 r_s1_last;
    logic                 r_s1_inrng;
    logic [ADDR_W-1:0]    r_s1_addr;

    // write from the edge at which the compare-stage item was read
    logic                 r_fw_valid;
    logic [ADDR_W-1:0]    r_fw_addr;
    logic                 r_fw_cand;
    logic [VALUE_W-1:0]   r_fw_snap;

    logic                 r_searched;
    logic [COUNT_W-1:0]   r_pass_count;

    // output register
    logic                 r_out_valid;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_kept;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_ignored;
    logic                 r_out_last;

    logic                 in_xfer;
    logic                 s1_fire;
    logic [EXT_W-1:0]     slot_ext;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 in_range;
    logic [VALUE_W-1:0]   cur_m;
    logic                 fw_hit;
    logic                 prev_cand;
    logic [VALUE_W-1:0]   prev_snap;
    logic                 test_ok;
    logic                 ignored;
    logic                 s1_we;
    logic                 kept;
    logic [COUNT_W-1:0]   n_pass_count;
    logic                 cand_we;
    logic [ADDR_W-1:0]    cand_wa;
    logic                 cand_wd;

    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_fire);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign slot_ext = EXT_W'(s_axis_tdata[SLOT_W-1:0]);
    assign rd_addr  = slot_ext[ADDR_W-1:0];
    assign in_range = CMP_W'(s_axis_tdata[SLOT_W-1:0]) < CMP_W'(SLOTS);

    always_comb begin
        case (r_value_width)
            VW_BYTE: cur_m = {24'd0, r_s1_cur[7:0]};
            VW_HALF: cur_m = {16'd0, r_s1_cur[15:0]};
            default: cur_m = r_s1_cur;
        endcase
    end

    assign fw_hit    = r_fw_valid && (r_fw_addr == r_s1_addr);
    assign prev_cand = fw_hit ? r_fw_cand : r_rd_cand;
    assign prev_snap = fw_hit ? r_fw_snap : r_rd_snap;

    always_comb begin
        case (r_filter_mode)
            FM_EQUAL:     test_ok = (cur_m == r_compare_value);
            FM_NOT_EQUAL: test_ok = (cur_m != r_compare_value);
            FM_GREATER:   test_ok = (cur_m >  prev_snap);
            FM_LESS:      test_ok = (cur_m <  prev_snap);
            FM_CHANGED:   test_ok = (cur_m != prev_snap);
            FM_UNCHANGED: test_ok = (cur_m == prev_snap);
            default:      test_ok = 1'b0;
        endcase
    end

    assign ignored = (r_s1_cmd == CMD_FILTER) && !r_searched;
    assign s1_we   = !ignored && r_s1_inrng;
    assign kept    = s1_we && ((r_s1_cmd == CMD_RESET) || (prev_cand && test_ok));
    assign n_pass_count = (kept && (r_pass_count != COUNT_MAX)) ?
                          r_pass_count + COUNT_W'(1) : r_pass_count;

    // one write port, shared by the clearing pass and the write-back
    assign cand_we = r_clr_busy || (s1_fire && s1_we);
    assign cand_wa = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign cand_wd = r_clr_busy ? 1'b0 : kept;

    always_ff @(posedge i_clk) begin
        if (cand_we) begin
            r_cand_mem[cand_wa] <= cand_wd;
        end
        if (in_xfer) begin
            r_rd_cand <= r_cand_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_we) begin
            r_snap_mem[r_s1_addr] <= cur_m;
        end
        if (in_xfer) begin
            r_rd_snap <= r_snap_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_width   <= VW_BYTE;
            r_filter_mode   <= FM_EQUAL;
            r_compare_value <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VALUE_WIDTH:   r_value_width   <= i_cfg_data[VWID_W-1:0];
                CFG_FILTER_MODE:   r_filter_mode   <= i_cfg_data[FMODE_W-1:0];
                CFG_COMPARE_VALUE: r_compare_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(SLOTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_fw_valid   <= 1'b0;
            r_searched   <= 1'b0;
            r_pass_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
                // capture the write that the fresh read missed
                r_fw_valid <= s1_fire && s1_we;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                if (s1_we && (r_s1_cmd == CMD_RESET)) begin
                    r_searched <= 1'b1;
                end
                r_pass_count <= r_s1_last ? '0 : n_pass_count;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd   <= s_axis_tuser;
            r_s1_slot  <= s_axis_tdata[SLOT_W-1:0];
            r_s1_cur   <= s_axis_tdata[47:16];
            r_s1_last  <= s_axis_tlast;
            r_s1_inrng <= in_range;
            r_s1_addr  <= rd_addr;
            r_fw_addr  <= r_s1_addr;
            r_fw_cand  <= kept;
            r_fw_snap  <= cur_m;
        end
        if (s1_fire) begin
            r_out_slot    <= r_s1_slot;
            r_out_kept    <= kept;
            r_out_count   <= n_pass_count;
            r_out_ignored <= ignored;
            r_out_last    <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_count, r_out_kept, r_out_slot};
    assign m_axis_tuser  = r_out_ignored;
    assign m_axis_tlast  = r_out_last;

    a_no_xfer_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready)
        else $error("input taken during clearing pass");

    a_stage_empty_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_valid && !r_out_valid)
        else $error("item in flight during clearing pass");

    a_ignored_not_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ignored) |-> !r_out_kept)
        else $error("ignored result marked kept");

    a_kept_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kept) |-> (r_out_count != '0))
        else $error("kept result with zero count");

    a_searched_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_searched) |-> r_searched)
        else $error("search flag cleared without reset");

endmodule
